### hdl/bead_centroid_mapper_defines.svh
// Assertion helpers for the bead centroid mapper.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef BEAD_CENTROID_MAPPER_DEFINES_SVH
`define BEAD_CENTROID_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS
`define BCM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define BCM_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define BCM_ASSERT(name, prop)
`define BCM_ASSERT_NEVER(name, expr)
`endif

`endif

### hdl/bcm_pkg.sv
`timescale 1ns / 1ps

package bcm_pkg;

  // Default bead size limit and fixed field widths
  localparam int MAX_ATOMS_PER_BEAD = 64;
  localparam int COORD_W            = 32;
  localparam int MASS_W             = 16;
  localparam int MODE_W             = 2;

  // Mapping modes; the spare code behaves as geometric centre
  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST    = 2'd0,
    MODE_GEOM     = 2'd1,
    MODE_MASS     = 2'd2,
    MODE_GEOM_ALT = 2'd3
  } map_mode_e;

  localparam map_mode_e MODE_RESET = MODE_GEOM;

  // What the back end does with a finished bead
  typedef enum logic {
    JOB_DIRECT = 1'b0,
    JOB_DIVIDE = 1'b1
  } job_kind_e;

  typedef enum logic {
    FR_IDLE,
    FR_ACC
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_state_e;

  // Queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### hdl/bead_centroid_mapper.sv
// In the dividing modes the bit-serial divider produces one quotient bit per cycle for SUM_W bits,
// SUM_W = 49 + clog2(MAX_ATOMS_PER_BEAD) (55 at default); first-atom mode bypasses the division.
// Atoms are stalled while one is captured (multiply) and then accumulated, or while a finished
// bead waits for queue space; the divider overlaps with the next bead via a 2-entry queue.
// Reset (rst_ni low, asynchronous): accumulators and queue empty, map_mode = 1.
`timescale 1ns / 1ps

module bead_centroid_mapper #(
  parameter int MAX_ATOMS_PER_BEAD = bcm_pkg::MAX_ATOMS_PER_BEAD
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic        [bcm_pkg::MODE_W-1:0]  cfg_data_i,
  // atom beats
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [bcm_pkg::COORD_W-1:0] atom_x_i,
  input  logic signed [bcm_pkg::COORD_W-1:0] atom_y_i,
  input  logic signed [bcm_pkg::COORD_W-1:0] atom_z_i,
  input  logic        [bcm_pkg::MASS_W-1:0]  atom_mass_i,
  input  logic                               last_of_bead_i,
  // bead beats
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bcm_pkg::COORD_W-1:0] bead_x_o,
  output logic signed [bcm_pkg::COORD_W-1:0] bead_y_o,
  output logic signed [bcm_pkg::COORD_W-1:0] bead_z_o,
  output logic                               status_o
);

  localparam int SUM_W = bcm_pkg::COORD_W + bcm_pkg::MASS_W + $clog2(MAX_ATOMS_PER_BEAD) + 1;
  localparam int WS_W  = bcm_pkg::MASS_W + $clog2(MAX_ATOMS_PER_BEAD) + 1;
  localparam int JOB_W = 1 + 3 * SUM_W + WS_W;

  bcm_pkg::map_mode_e map_mode_q;
  bcm_pkg::q_status_t q_status;
  logic               push;
  logic               pop;
  logic [JOB_W-1:0]   job_in;
  logic [JOB_W-1:0]   job_out;

  // Mode register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q <= bcm_pkg::MODE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      map_mode_q <= bcm_pkg::map_mode_e'(cfg_data_i);
    end
  end

  bcm_front #(
    .MAX_ATOMS_PER_BEAD (MAX_ATOMS_PER_BEAD),
    .JOB_W              (JOB_W)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .atom_x_i       (atom_x_i),
    .atom_y_i       (atom_y_i),
    .atom_z_i       (atom_z_i),
    .atom_mass_i    (atom_mass_i),
    .last_of_bead_i (last_of_bead_i),
    .mode_i         (map_mode_q),
    .q_status_i     (q_status),
    .push_o         (push),
    .job_o          (job_in)
  );

  bcm_queue #(
    .JOB_W (JOB_W)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (job_in),
    .pop_i    (pop),
    .data_o   (job_out),
    .status_o (q_status)
  );

  bcm_divider #(
    .MAX_ATOMS_PER_BEAD (MAX_ATOMS_PER_BEAD),
    .JOB_W              (JOB_W)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bead_x_o    (bead_x_o),
    .bead_y_o    (bead_y_o),
    .bead_z_o    (bead_z_o),
    .status_o    (status_o)
  );

endmodule

### hdl/bcm_front.sv
`timescale 1ns / 1ps
`include "bead_centroid_mapper_defines.svh"

module bcm_front #(
  parameter int MAX_ATOMS_PER_BEAD = bcm_pkg::MAX_ATOMS_PER_BEAD,
  parameter int JOB_W              = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [bcm_pkg::COORD_W-1:0] atom_x_i,
  input  logic signed [bcm_pkg::COORD_W-1:0] atom_y_i,
  input  logic signed [bcm_pkg::COORD_W-1:0] atom_z_i,
  input  logic        [bcm_pkg::MASS_W-1:0]  atom_mass_i,
  input  logic                               last_of_bead_i,
  input  bcm_pkg::map_mode_e                 mode_i,
  input  bcm_pkg::q_status_t                 q_status_i,
  output logic                               push_o,
  output logic        [JOB_W-1:0]            job_o
);

  localparam int CW     = bcm_pkg::COORD_W;
  localparam int MW     = bcm_pkg::MASS_W;
  localparam int CNT_W  = $clog2(MAX_ATOMS_PER_BEAD + 1);
  localparam int SUM_W  = CW + MW + $clog2(MAX_ATOMS_PER_BEAD) + 1;
  localparam int WS_W   = MW + $clog2(MAX_ATOMS_PER_BEAD) + 1;
  localparam int PROD_W = CW + MW + 1;

  bcm_pkg::front_state_e state_q, state_d;

  // Atom beat held for the accumulate cycle
  logic signed [PROD_W-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [CW-1:0]     ax_q, ay_q, az_q;
  logic        [MW-1:0]     w_q;
  logic                     last_q;
  bcm_pkg::map_mode_e       mode_q;

  // Bead accumulators
  logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
  logic signed [SUM_W-1:0] sum_x_n, sum_y_n, sum_z_n;
  logic        [WS_W-1:0]  wsum_q, wsum_n;
  logic        [CNT_W-1:0] cnt_q, cnt_n;
  logic signed [CW-1:0]    first_x_q, first_y_q, first_z_q;
  logic signed [CW-1:0]    first_x_n, first_y_n, first_z_n;

  logic              in_acc;
  logic [MW-1:0]     w;
  logic              take;
  logic              acc_en;
  logic              clr;
  logic              push;
  bcm_pkg::job_kind_e kind;

  assign in_stall_o = (state_q != bcm_pkg::FR_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Weight: mass in centre-of-mass mode, one otherwise
  assign w = (mode_i == bcm_pkg::MODE_MASS) ? atom_mass_i : MW'(1);

  // Capture stage: one multiply per axis
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prod_x_q <= PROD_W'(atom_x_i) * PROD_W'($signed({1'b0, w}));
      prod_y_q <= PROD_W'(atom_y_i) * PROD_W'($signed({1'b0, w}));
      prod_z_q <= PROD_W'(atom_z_i) * PROD_W'($signed({1'b0, w}));
      ax_q     <= atom_x_i;
      ay_q     <= atom_y_i;
      az_q     <= atom_z_i;
      w_q      <= w;
      last_q   <= last_of_bead_i;
      mode_q   <= mode_i;
    end
  end

  // Accumulate, dropping atoms past the bead limit
  always_comb begin
    take      = (cnt_q < CNT_W'(MAX_ATOMS_PER_BEAD));
    sum_x_n   = take ? sum_x_q + SUM_W'(prod_x_q) : sum_x_q;
    sum_y_n   = take ? sum_y_q + SUM_W'(prod_y_q) : sum_y_q;
    sum_z_n   = take ? sum_z_q + SUM_W'(prod_z_q) : sum_z_q;
    wsum_n    = take ? wsum_q + WS_W'(w_q) : wsum_q;
    cnt_n     = take ? cnt_q + CNT_W'(1) : cnt_q;
    first_x_n = (take && cnt_q == '0) ? ax_q : first_x_q;
    first_y_n = (take && cnt_q == '0) ? ay_q : first_y_q;
    first_z_n = (take && cnt_q == '0) ? az_q : first_z_q;
  end

  // Classify the finished bead
  assign kind  = (mode_q == bcm_pkg::MODE_FIRST) ? bcm_pkg::JOB_DIRECT : bcm_pkg::JOB_DIVIDE;
  assign job_o = (kind == bcm_pkg::JOB_DIRECT) ?
                 {kind, SUM_W'(first_x_n), SUM_W'(first_y_n), SUM_W'(first_z_n), wsum_n} :
                 {kind, sum_x_n, sum_y_n, sum_z_n, wsum_n};
  assign push_o = push;

  // Front state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcm_pkg::FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    acc_en  = 1'b0;
    clr     = 1'b0;
    push    = 1'b0;
    unique case (state_q)
      bcm_pkg::FR_IDLE: begin
        if (in_acc) begin
          state_d = bcm_pkg::FR_ACC;
        end
      end
      bcm_pkg::FR_ACC: begin
        if (!last_q) begin
          acc_en  = 1'b1;
          state_d = bcm_pkg::FR_IDLE;
        end else if (!q_status_i.full) begin
          push    = 1'b1;
          clr     = 1'b1;
          state_d = bcm_pkg::FR_IDLE;
        end
      end
      default: state_d = bcm_pkg::FR_IDLE;
    endcase
  end

  // Accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      sum_z_q   <= '0;
      wsum_q    <= '0;
      cnt_q     <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      first_z_q <= '0;
    end else if (clr) begin
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      sum_z_q   <= '0;
      wsum_q    <= '0;
      cnt_q     <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      first_z_q <= '0;
    end else if (acc_en) begin
      sum_x_q   <= sum_x_n;
      sum_y_q   <= sum_y_n;
      sum_z_q   <= sum_z_n;
      wsum_q    <= wsum_n;
      cnt_q     <= cnt_n;
      first_x_q <= first_x_n;
      first_y_q <= first_y_n;
      first_z_q <= first_z_n;
    end
  end

  `BCM_ASSERT(a_cnt_limit, cnt_q <= CNT_W'(MAX_ATOMS_PER_BEAD))
  `BCM_ASSERT(a_push_clears, push |=> (cnt_q == '0 && wsum_q == '0))

endmodule

### hdl/bcm_queue.sv
`timescale 1ns / 1ps
`include "bead_centroid_mapper_defines.svh"

// Two-slot job queue; slot 0 is always the head.
module bcm_queue #(
  parameter int JOB_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [JOB_W-1:0]   data_i,
  input  logic               pop_i,
  output logic [JOB_W-1:0]   data_o,
  output bcm_pkg::q_status_t status_o
);

  logic [JOB_W-1:0] slot0_q, slot1_q;
  logic [1:0]       count_q;

  assign data_o         = slot0_q;
  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (push_i && !pop_i) begin
      count_q <= count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_q <= count_q - 2'd1;
    end
  end

  // Slot data
  always_ff @(posedge clk_i) begin
    case ({push_i, pop_i})
      2'b10: begin
        if (count_q == 2'd0) begin
          slot0_q <= data_i;
        end else begin
          slot1_q <= data_i;
        end
      end
      2'b01: begin
        slot0_q <= slot1_q;
      end
      2'b11: begin
        if (count_q == 2'd1) begin
          slot0_q <= data_i;
        end else begin
          slot0_q <= slot1_q;
          slot1_q <= data_i;
        end
      end
      default: begin
      end
    endcase
  end

  `BCM_ASSERT_NEVER(a_no_overflow, push_i && status_o.full)
  `BCM_ASSERT_NEVER(a_no_underflow, pop_i && status_o.empty)

endmodule

### hdl/bcm_divider.sv
`timescale 1ns / 1ps
`include "bead_centroid_mapper_defines.svh"

// Back end: three restoring dividers sharing one divisor, one bit per cycle.
module bcm_divider #(
  parameter int MAX_ATOMS_PER_BEAD = bcm_pkg::MAX_ATOMS_PER_BEAD,
  parameter int JOB_W              = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bcm_pkg::q_status_t                 q_status_i,
  input  logic        [JOB_W-1:0]            job_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bcm_pkg::COORD_W-1:0] bead_x_o,
  output logic signed [bcm_pkg::COORD_W-1:0] bead_y_o,
  output logic signed [bcm_pkg::COORD_W-1:0] bead_z_o,
  output logic                               status_o
);

  localparam int CW     = bcm_pkg::COORD_W;
  localparam int SUM_W  = CW + bcm_pkg::MASS_W + $clog2(MAX_ATOMS_PER_BEAD) + 1;
  localparam int WS_W   = bcm_pkg::MASS_W + $clog2(MAX_ATOMS_PER_BEAD) + 1;
  localparam int STEP_W = $clog2(SUM_W + 1);

  bcm_pkg::back_state_e state_q, state_d;
  bcm_pkg::job_kind_e   kind_q;

  logic [SUM_W-1:0]  dvd_q [3];
  logic [WS_W-1:0]   rem_q [3];
  logic [2:0]        neg_q;
  logic [WS_W-1:0]   dsr_q;
  logic              zero_q;
  logic [STEP_W-1:0] step_q;

  logic [SUM_W-1:0]  dvd_nx [3];
  logic [WS_W-1:0]   rem_nx [3];
  logic [SUM_W-1:0]  dvd_ld [3];
  logic [2:0]        neg_ld;
  logic [CW-1:0]     res [3];
  logic [WS_W:0]     rem_sh [3];
  logic [SUM_W-1:0]  lane_in;

  bcm_pkg::job_kind_e job_kind;
  logic [WS_W-1:0]    job_dsr;

  logic out_valid_q;
  logic out_free;
  logic load;
  logic step_en;
  logic out_load;
  logic signed [CW-1:0] bead_x_q, bead_y_q, bead_z_q;
  logic                 status_q;

  // Unpack the head job: kind, three dividends, divisor
  assign job_kind = bcm_pkg::job_kind_e'(job_i[JOB_W-1]);
  assign job_dsr  = job_i[WS_W-1:0];

  always_comb begin
    lane_in = '0;
    for (int i = 0; i < 3; i++) begin
      lane_in   = job_i[JOB_W-2-i*SUM_W -: SUM_W];
      neg_ld[i] = (job_kind == bcm_pkg::JOB_DIVIDE) && lane_in[SUM_W-1];
      dvd_ld[i] = neg_ld[i] ? -lane_in : lane_in;
    end
  end

  // One restoring step per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem_q[i], dvd_q[i][SUM_W-1]};
      if (rem_sh[i] >= {1'b0, dsr_q}) begin
        rem_nx[i] = WS_W'(rem_sh[i] - {1'b0, dsr_q});
        dvd_nx[i] = {dvd_q[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_nx[i] = rem_sh[i][WS_W-1:0];
        dvd_nx[i] = {dvd_q[i][SUM_W-2:0], 1'b0};
      end
    end
  end

  // Final lane values: pass-through, forced zero, or signed quotient
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (kind_q == bcm_pkg::JOB_DIRECT) begin
        res[i] = dvd_q[i][CW-1:0];
      end else if (zero_q) begin
        res[i] = '0;
      end else if (neg_q[i]) begin
        res[i] = -dvd_q[i][CW-1:0];
      end else begin
        res[i] = dvd_q[i][CW-1:0];
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Back state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcm_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    load     = 1'b0;
    step_en  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      bcm_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          load = 1'b1;
          if (job_kind == bcm_pkg::JOB_DIRECT || job_dsr == '0) begin
            state_d = bcm_pkg::BK_DONE;
          end else begin
            state_d = bcm_pkg::BK_RUN;
          end
        end
      end
      bcm_pkg::BK_RUN: begin
        step_en = 1'b1;
        if (step_q == STEP_W'(1)) begin
          state_d = bcm_pkg::BK_DONE;
        end
      end
      bcm_pkg::BK_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = bcm_pkg::BK_IDLE;
        end
      end
      default: state_d = bcm_pkg::BK_IDLE;
    endcase
  end

  assign pop_o = load;

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (load) begin
      step_q <= STEP_W'(SUM_W);
    end else if (step_en) begin
      step_q <= step_q - STEP_W'(1);
    end
  end

  // Divider datapath
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= job_kind;
      dsr_q  <= job_dsr;
      zero_q <= (job_kind == bcm_pkg::JOB_DIVIDE) && (job_dsr == '0);
      neg_q  <= neg_ld;
      for (int i = 0; i < 3; i++) begin
        dvd_q[i] <= dvd_ld[i];
        rem_q[i] <= '0;
      end
    end else if (step_en) begin
      for (int i = 0; i < 3; i++) begin
        dvd_q[i] <= dvd_nx[i];
        rem_q[i] <= rem_nx[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      bead_x_q <= res[0];
      bead_y_q <= res[1];
      bead_z_q <= res[2];
      status_q <= (kind_q == bcm_pkg::JOB_DIVIDE) && zero_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bead_x_o    = bead_x_q;
  assign bead_y_o    = bead_y_q;
  assign bead_z_o    = bead_z_q;
  assign status_o    = status_q;

  `BCM_ASSERT(a_done_emits, (state_q == bcm_pkg::BK_DONE && out_free) |=> out_valid_o)
  `BCM_ASSERT_NEVER(a_run_nonzero, state_q == bcm_pkg::BK_RUN && (dsr_q == '0 || step_q == '0))

endmodule
